>>> design/mlss_pkg.sv
// Shared types, field widths, codes and reset values of the shift search block.
package mlss_pkg;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 10;
    localparam int LOG_W      = 25;
    localparam int DIST_W     = 16;
    localparam int SHIFT_W    = 11;
    localparam int LEN_W      = 11;
    localparam int SCORE_W    = 33;
    localparam int USED_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    // sample plus shift, signed
    localparam int POS_W      = 18;
    // unsigned width that holds any table depth or length
    localparam int LEN_CMP_W  = 17;

    localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ESTIMATE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SHIFT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SHIFT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LOG    = 2'd3;

    localparam logic signed [SHIFT_W-1:0] RST_MIN_SHIFT    = -11'sd50;
    localparam logic signed [SHIFT_W-1:0] RST_MAX_SHIFT    = 11'sd200;
    localparam logic        [LEN_W-1:0]   RST_TABLE_LENGTH = 11'd1024;
    localparam logic signed [LOG_W-1:0]   RST_FLOOR_LOG    = -25'sd754511;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 33'sh0_FFFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 33'sh1_0000_0000;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic last;
        logic cmp;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_empty;
        logic count_zero;
        logic shift_last;
        logic sum_done;
    } t_dp_status;

endpackage

>>> design/mlss_in_if.sv
// Request channel of the shift search block: valid, ready and the request fields.
interface mlss_in_if import mlss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [MODE_W-1:0] mode;
    logic        [IDX_W-1:0]  entry_index;
    logic signed [LOG_W-1:0]  log_prob;
    logic signed [DIST_W-1:0] pair_distance;

    modport source (output valid, mode, entry_index, log_prob, pair_distance, input ready);
    modport sink   (input valid, mode, entry_index, log_prob, pair_distance, output ready);
endinterface

>>> design/mlss_out_if.sv
// Result channel of the shift search block: valid, ready and the result fields.
interface mlss_out_if import mlss_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SHIFT_W-1:0] best_shift;
    logic signed [SCORE_W-1:0] best_score;
    logic        [USED_W-1:0]  samples_used;

    modport source (output valid, best_shift, best_score, samples_used, input ready);
    modport sink   (input valid, best_shift, best_score, samples_used, output ready);
endinterface

>>> design/mlss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlss_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/mlss_ctrl.sv
// Controller of the shift search: walks shifts and samples, hands out results.
module mlss_ctrl import mlss_pkg::*; #(
    parameter int MAX_SAMPLES = 256,
    parameter int CW  = $clog2(MAX_SAMPLES + 1),
    parameter int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_in_mode,
    input  logic              i_out_ready,
    input  t_dp_status        i_status,
    input  logic [CW-1:0]     i_count,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_dp_cmd           o_cmd,
    output logic [SAW-1:0]    o_idx
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic          last_sample;

    assign last_sample = ({1'b0, r_idx} + {{CW{1'b0}}, 1'b1}) == {1'b0, i_count};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_mode == MODE_ESTIMATE) begin
                        o_cmd.start = 1'b1;
                        n_idx       = '0;
                        if (i_status.range_empty) begin
                            n_state = S_FINISH;
                        end else if (i_status.count_zero) begin
                            n_state = S_CMP;
                        end else begin
                            n_state = S_ISSUE;
                        end
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.last  = last_sample;
                if (last_sample) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            S_WAIT: begin
                if (i_status.sum_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_idx     = '0;
                if (i_status.shift_last) begin
                    n_state = S_FINISH;
                end else if (i_status.count_zero) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_idx       = r_idx[SAW-1:0];
endmodule

>>> design/mlss_dpath.sv
// Datapath of the shift search: config, stores, lookup pipeline, accumulator, best tracker.
module mlss_dpath import mlss_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_SAMPLES = 256,
    parameter int CW  = $clog2(MAX_SAMPLES + 1),
    parameter int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int TAW = $clog2(TABLE_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic        [MODE_W-1:0]  i_mode,
    input  logic        [IDX_W-1:0]   i_entry_index,
    input  logic signed [LOG_W-1:0]   i_log_prob,
    input  logic signed [DIST_W-1:0]  i_pair_distance,
    input  t_dp_cmd                   i_cmd,
    input  logic [SAW-1:0]            i_idx,
    output t_dp_status                o_status,
    output logic [CW-1:0]             o_count,
    output logic signed [SHIFT_W-1:0] o_best_shift,
    output logic signed [SCORE_W-1:0] o_best_score,
    output logic        [USED_W-1:0]  o_samples_used
);
    localparam logic [LEN_CMP_W-1:0] DEPTH_LEN = LEN_CMP_W'(TABLE_DEPTH);
    localparam logic [CW-1:0]        MAX_CNT   = CW'(MAX_SAMPLES);

    logic signed [SHIFT_W-1:0] r_min_shift, r_max_shift;
    logic        [LEN_W-1:0]   r_table_length;
    logic signed [LOG_W-1:0]   r_floor_log;
    logic [CW-1:0]             r_count;

    logic signed [SHIFT_W-1:0] r_shift, r_best_shift;
    logic signed [SCORE_W-1:0] r_sum, r_best_score;
    logic                      r_have;
    logic                      r_v1, r_last1, r_v2, r_last2, r_inr2;

    logic signed [SHIFT_W-1:0] r_out_shift;
    logic signed [SCORE_W-1:0] r_out_score;
    logic        [USED_W-1:0]  r_out_used;

    logic                      tab_we, smp_we, entry_ok;
    logic [LEN_CMP_W-1:0]      entry_ext, len_eff;
    logic signed [DIST_W-1:0]  smp_rdata;
    logic signed [LOG_W-1:0]   tab_rdata, term;
    logic signed [POS_W-1:0]   pos;
    logic                      in_range;
    logic signed [SCORE_W:0]   acc;
    logic signed [SCORE_W-1:0] acc_sat;

    // write side of the stores
    assign entry_ext = {{(LEN_CMP_W-IDX_W){1'b0}}, i_entry_index};
    assign entry_ok  = entry_ext < DEPTH_LEN;
    assign tab_we    = i_cmd.accept && (i_mode == MODE_WRITE) && entry_ok;
    assign smp_we    = i_cmd.accept && (i_mode == MODE_APPEND) && (r_count < MAX_CNT);

    // stage one: sample read data plus shift gives the table index
    assign pos = {{(POS_W-DIST_W){smp_rdata[DIST_W-1]}}, smp_rdata}
               + {{(POS_W-SHIFT_W){r_shift[SHIFT_W-1]}}, r_shift};
    assign len_eff  = ({{(LEN_CMP_W-LEN_W){1'b0}}, r_table_length} > DEPTH_LEN)
                    ? DEPTH_LEN : {{(LEN_CMP_W-LEN_W){1'b0}}, r_table_length};
    assign in_range = !pos[POS_W-1] && (pos[LEN_CMP_W-1:0] < len_eff);

    mlss_ram #(.WIDTH(DIST_W), .DEPTH(MAX_SAMPLES), .ADDR_W(SAW)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (r_count[SAW-1:0]),
        .i_wdata (i_pair_distance),
        .i_raddr (i_idx),
        .o_rdata (smp_rdata)
    );

    mlss_ram #(.WIDTH(LOG_W), .DEPTH(TABLE_DEPTH), .ADDR_W(TAW)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (entry_ext[TAW-1:0]),
        .i_wdata (i_log_prob),
        .i_raddr (pos[TAW-1:0]),
        .o_rdata (tab_rdata)
    );

    // stage two: saturating accumulate
    assign term = r_inr2 ? tab_rdata : r_floor_log;
    assign acc  = {r_sum[SCORE_W-1], r_sum} + {{(SCORE_W+1-LOG_W){term[LOG_W-1]}}, term};
    always_comb begin
        if (acc[SCORE_W] != acc[SCORE_W-1]) begin
            acc_sat = acc[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end else begin
            acc_sat = acc[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_shift    <= RST_MIN_SHIFT;
            r_max_shift    <= RST_MAX_SHIFT;
            r_table_length <= RST_TABLE_LENGTH;
            r_floor_log    <= RST_FLOOR_LOG;
            r_count        <= '0;
            r_have         <= 1'b0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_last1        <= 1'b0;
            r_last2        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MIN_SHIFT:    r_min_shift    <= i_cfg_data[SHIFT_W-1:0];
                    REG_MAX_SHIFT:    r_max_shift    <= i_cfg_data[SHIFT_W-1:0];
                    REG_TABLE_LENGTH: r_table_length <= i_cfg_data[LEN_W-1:0];
                    REG_FLOOR_LOG:    r_floor_log    <= i_cfg_data[LOG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (smp_we) begin
                r_count <= r_count + {{(CW-1){1'b0}}, 1'b1};
            end else if (i_cmd.accept && (i_mode == MODE_CLEAR)) begin
                r_count <= '0;
            end
            r_v1    <= i_cmd.issue;
            r_last1 <= i_cmd.last;
            r_v2    <= r_v1;
            r_last2 <= r_v1 && r_last1;
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end else if (i_cmd.cmp) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inr2 <= in_range;
        if (i_cmd.start) begin
            r_shift      <= r_min_shift;
            r_best_shift <= r_min_shift;
            r_best_score <= '0;
            r_sum        <= '0;
        end else if (i_cmd.cmp) begin
            // strict compare: earliest shift keeps a tie
            if (!r_have || (r_sum > r_best_score)) begin
                r_best_shift <= r_shift;
                r_best_score <= r_sum;
            end
            r_shift <= r_shift + 11'sd1;
            r_sum   <= '0;
        end else if (r_v2) begin
            r_sum <= acc_sat;
        end
        if (i_cmd.load_out) begin
            r_out_shift <= r_best_shift;
            r_out_score <= r_best_score;
            r_out_used  <= USED_W'(r_count);
        end
    end

    assign o_status.range_empty = !(r_min_shift < r_max_shift);
    assign o_status.count_zero  = (r_count == '0);
    assign o_status.shift_last  = ({r_shift[SHIFT_W-1], r_shift} + 12'sd1)
                                == {r_max_shift[SHIFT_W-1], r_max_shift};
    assign o_status.sum_done    = r_v2 && r_last2;
    assign o_count              = r_count;
    assign o_best_shift         = r_out_shift;
    assign o_best_score         = r_out_score;
    assign o_samples_used       = r_out_used;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("sample count above capacity");
    a_cmp_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cmp |-> !(r_v1 || r_v2))
        else $error("shift compared while lookups in flight");
    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !(r_v1 || r_v2 || i_cmd.issue))
        else $error("request accepted during a search");
    a_done_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.sum_done |-> $past(i_cmd.last, 2))
        else $error("sum done without a last sample issued");
`endif
endmodule

>>> design/max_likelihood_shift_search.sv
// Top level of the maximum-likelihood shift search block.
//
// Maximum-likelihood shift search over a Q8.16 log-probability table. Each
// request carries a mode: write a table entry, append a pair distance to the
// sample store (dropped once MAX_SAMPLES are held), clear the samples, or
// estimate. Write, append and clear requests are accepted in idle and produce
// no result. An estimate tries every shift from min_shift up to but not
// including max_shift; for each shift it adds, with saturation to 33 bits,
// the table entry at sample plus shift, or floor_log_prob when that index lies
// outside [0, min(table_length, TABLE_DEPTH)). It returns the shift with the
// strictly greatest sum (earliest wins ties), that sum, and the sample count;
// an empty shift range returns min_shift with score zero. Samples are fed
// one per cycle through a two-stage lookup pipeline into one accumulator, the
// rate set by the single read port of the table RAM; after the last sample of
// each shift the pipeline drains before the compare, and with no samples
// stored each shift is compared directly. New requests are held off until
// the estimate has finished; a finished result waits in an output register
// while later requests are taken. Table entries and samples that were never
// written read as arbitrary values. The user is to write configuration through
// i_cfg_we/i_cfg_index/i_cfg_data while idle; the block does not enforce it.
module max_likelihood_shift_search import mlss_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_SAMPLES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mlss_in_if.sink               i_in,
    mlss_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int TAW = $clog2(TABLE_DEPTH);

    t_dp_cmd        cmd;
    t_dp_status     status;
    logic [CW-1:0]  count;
    logic [SAW-1:0] idx;

    // sequencing: shift loop, sample loop, output register handshake
    mlss_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .SAW(SAW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .i_count     (count),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    // stores, lookup pipeline, accumulate and best-shift tracking
    mlss_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .SAW         (SAW),
        .TAW         (TAW)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_in.mode),
        .i_entry_index   (i_in.entry_index),
        .i_log_prob      (i_in.log_prob),
        .i_pair_distance (i_in.pair_distance),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .o_status        (status),
        .o_count         (count),
        .o_best_shift    (o_out.best_shift),
        .o_best_score    (o_out.best_score),
        .o_samples_used  (o_out.samples_used)
    );
endmodule
